[hdl/wsfir_pkg.sv]
`default_nettype none

package wsfir_pkg;

  localparam int TAPS   = 512;
  localparam int HALF   = TAPS / 2;
  localparam int TAP_W  = $clog2(TAPS);
  localparam int HALF_W = $clog2(HALF);

  localparam logic [15:0] CUTOFF_RESET = 16'd32768;

  // Register index bit of the configuration address (paddr bit 2).
  localparam logic REG_CUTOFF = 1'b0;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [31:0] PI30    = 32'd3373259426;

  // Odd Taylor terms of sin(pi/2 * z), Q0.30 argument.
  localparam logic [31:0] ST1  = 32'd1686629713;
  localparam logic [31:0] ST3  = 32'd693598668;
  localparam logic [31:0] ST5  = 32'd85569306;
  localparam logic [31:0] ST7  = 32'd5026995;
  localparam logic [31:0] ST9  = 32'd172272;
  localparam logic [31:0] ST11 = 32'd3864;

  // Blackman-Harris weights in Q1.30.
  localparam logic [31:0] WA0 = 32'd385204879;
  localparam logic [31:0] WA1 = 32'd524297395;
  localparam logic [31:0] WA2 = 32'd151698245;
  localparam logic [31:0] WA3 = 32'd12541305;

  localparam int NHORNER = 5;
  typedef logic [30:0] horner_t [NHORNER];
  localparam horner_t HORNER_K = '{ST9[30:0], ST7[30:0], ST5[30:0], ST3[30:0], ST1[30:0]};

  typedef logic [30:0] rom_t [HALF];

  function automatic logic signed [63:0] sine_q30(input logic [31:0] ph);
    logic [63:0] r;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] s;
    logic [63:0] mag;
    r   = {34'd0, ph[29:0]};
    z   = ph[30] ? ({32'd0, ONE_Q30} - r) : r;
    z2  = (z * z) >> 30;
    s   = {32'd0, ST11};
    s   = {32'd0, ST9} - ((z2 * s) >> 30);
    s   = {32'd0, ST7} - ((z2 * s) >> 30);
    s   = {32'd0, ST5} - ((z2 * s) >> 30);
    s   = {32'd0, ST3} - ((z2 * s) >> 30);
    s   = {32'd0, ST1} - ((z2 * s) >> 30);
    mag = (z * s) >> 30;
    if (mag > {32'd0, ONE_Q30}) begin
      mag = {32'd0, ONE_Q30};
    end
    return ph[31] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [63:0] mul_q30(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic        neg;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] p;
    neg = a[63] != b[63];
    ma  = a[63] ? 64'(-a) : 64'(a);
    mb  = b[63] ? 64'(-b) : 64'(b);
    p   = (ma * mb) >> 30;
    return neg ? -$signed(p) : $signed(p);
  endfunction

  function automatic logic signed [63:0] cos_harm(input int j, input int m);
    logic [63:0] idx;
    logic [63:0] ph;
    idx = (64'(m) * 64'(j)) % TAPS;
    ph  = (idx << 32) / TAPS;
    return sine_q30(ph[31:0] + ONE_Q30);
  endfunction

  function automatic rom_t win_table();
    rom_t               tab;
    logic signed [63:0] w;
    for (int j = 0; j < HALF; j++) begin
      w = $signed({32'd0, WA0})
          - mul_q30($signed({32'd0, WA1}), cos_harm(j, 1))
          + mul_q30($signed({32'd0, WA2}), cos_harm(j, 2))
          - mul_q30($signed({32'd0, WA3}), cos_harm(j, 3));
      if (w < 0) begin
        w = 0;
      end
      if (w > $signed({32'd0, ONE_Q30})) begin
        w = $signed({32'd0, ONE_Q30});
      end
      tab[j] = w[30:0];
    end
    return tab;
  endfunction

  // round(2^32 / (pi * k)) for k = 1 .. HALF, by restoring long division.
  function automatic rom_t rcp_table();
    rom_t        tab;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    for (int k = 1; k <= HALF; k++) begin
      d   = {32'd0, PI30} * 64'(k);
      num = (64'd1 << 62) + (d >> 1);
      rem = '0;
      q   = '0;
      for (int i = 63; i >= 0; i--) begin
        rem = {rem[62:0], num[i]};
        if (rem >= d) begin
          rem  = rem - d;
          q[i] = 1'b1;
        end
      end
      tab[k-1] = q[30:0];
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

[hdl/windowed_sinc_fir_coefficient_generator_top.sv]
// Windowed-sinc lowpass coefficient generator, twelve register stages.
// Throughput: one tap per cycle unless m_tready holds the output; each stage holds
// one item and moves on as soon as the stage after it is empty or advancing, so
// stalls only back up as far as needed.
// Reset (synchronous, rst high) empties the pipeline and sets cutoff to 0.5.
`default_nettype none

module windowed_sinc_fir_coefficient_generator_top
  import wsfir_pkg::*;
#(
  parameter int COEF_BITS = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [15:0]             s_tdata,   // [8:0] tap_index
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  // [8:0] tap_number, then coefficient
  output logic [((TAP_W + COEF_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [2:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int TDATA_W = ((TAP_W + COEF_BITS + 7) / 8) * 8;
  localparam int NS      = 12;
  localparam int SH      = 63 - COEF_BITS;
  localparam logic [63:0] RND     = 64'd1 << (SH - 1);
  localparam logic [63:0] CEN_RND = 64'd1 << 15;
  localparam rom_t WIN_ROM = win_table();
  localparam rom_t RCP_ROM = rcp_table();

  logic [15:0] cutoff;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CUTOFF) ? {16'd0, cutoff} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= CUTOFF_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CUTOFF)) begin
      cutoff <= pwdata[15:0];
    end
  end

  // Stage control: a stage may load when m_tready is high or when it or any stage after it is empty.
  logic [NS:1] v;
  logic [NS:1] en;
  logic [NS:1] v_in;

  assign v_in = {v[NS-1:1], s_tvalid};

  for (genvar g = 1; g <= NS; g++) begin : g_en
    assign en[g] = m_tready || !(&v[NS:g]);
  end

  assign s_tready = en[1];
  assign m_tvalid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 1; i <= NS; i++) begin
        if (en[i]) begin
          v[i] <= v_in[i];
        end
      end
    end
  end

  // Payload registers.
  logic [TAP_W-1:0]  tap_pipe [1:NS];
  logic              ctr_pipe [1:11];
  logic              sgn_pipe [2:11];
  logic [HALF_W-1:0] j1;
  logic [TAP_W-1:0]  k1;
  logic [30:0]       z_pipe   [2:8];
  logic [30:0]       win_pipe [2:10];
  logic [30:0]       rcp_pipe [2:9];
  logic [30:0]       z2_pipe  [3:7];
  logic [30:0]       s_pipe   [4:8];
  logic [30:0]       mag9;
  logic [29:0]       sinc10;
  logic [60:0]       p11;
  logic [COEF_BITS-1:0] coef;

  // Stage 1: fold the tap onto the lower half and find its distance from the centre.
  logic [TAP_W-1:0]  t_in;
  logic [TAP_W:0]    mirror;
  logic [HALF_W-1:0] j_sel;

  assign t_in   = s_tdata[TAP_W-1:0];
  assign mirror = (TAP_W+1)'(TAPS) - {1'b0, t_in};
  assign j_sel  = (t_in < TAP_W'(HALF)) ? t_in[HALF_W-1:0] : mirror[HALF_W-1:0];

  // Stage 2: sinc phase and quarter-wave fold; table reads.
  logic [24:0]       ph_prod;
  logic [29:0]       ph_r;
  logic [30:0]       z_fold;
  logic [TAP_W-1:0]  k_m1;

  assign ph_prod = cutoff * k1;
  assign ph_r    = {ph_prod[13:0], 16'd0};
  assign z_fold  = ph_prod[14] ? (31'(ONE_Q30) - {1'b0, ph_r}) : {1'b0, ph_r};
  assign k_m1    = k1 - TAP_W'(1);

  // Stage 3: z squared.
  logic [61:0] zz;
  assign zz = z_pipe[2] * z_pipe[2];

  // Stages 4 to 8: one Horner step each.
  logic [30:0] hs_in [4:8];
  logic [61:0] hp    [4:8];

  assign hs_in[4] = ST11[30:0];
  for (genvar g = 5; g <= 8; g++) begin : g_hin
    assign hs_in[g] = s_pipe[g-1];
  end
  for (genvar g = 4; g <= 8; g++) begin : g_hmul
    assign hp[g] = z2_pipe[g-1] * hs_in[g];
  end

  // Stage 9: sine magnitude, clamped to one.
  logic [61:0] zs;
  logic [31:0] zs_q;
  assign zs   = z_pipe[8] * s_pipe[8];
  assign zs_q = zs[61:30];

  // Stage 10: sinc = |sin| / (pi k).
  logic [61:0] sp;
  assign sp = mag9 * rcp_pipe[9];

  // Stage 12: rounding, sign and the centre tap.
  logic [63:0]          rsum;
  logic [COEF_BITS-2:0] mag_r;
  logic [COEF_BITS-1:0] side;
  logic [63:0]          csum;
  logic [COEF_BITS-1:0] cen;

  assign rsum  = 64'(p11) + RND;
  assign mag_r = rsum[SH +: COEF_BITS-1];
  assign side  = sgn_pipe[11] ? -{1'b0, mag_r} : {1'b0, mag_r};
  // Centre tap is 2f; it can never reach the saturation limit.
  assign csum  = (64'(cutoff) << (COEF_BITS - 2)) + CEN_RND;
  assign cen   = csum[16 +: COEF_BITS];

  always_ff @(posedge clk) begin
    for (int i = 2; i <= NS; i++) begin
      if (en[i]) begin
        tap_pipe[i] <= tap_pipe[i-1];
      end
    end
    for (int i = 2; i <= 11; i++) begin
      if (en[i]) begin
        ctr_pipe[i] <= ctr_pipe[i-1];
      end
    end
    for (int i = 3; i <= 11; i++) begin
      if (en[i]) begin
        sgn_pipe[i] <= sgn_pipe[i-1];
      end
    end
    for (int i = 3; i <= 8; i++) begin
      if (en[i]) begin
        z_pipe[i] <= z_pipe[i-1];
      end
    end
    for (int i = 3; i <= 10; i++) begin
      if (en[i]) begin
        win_pipe[i] <= win_pipe[i-1];
      end
    end
    for (int i = 3; i <= 9; i++) begin
      if (en[i]) begin
        rcp_pipe[i] <= rcp_pipe[i-1];
      end
    end
    for (int i = 4; i <= 7; i++) begin
      if (en[i]) begin
        z2_pipe[i] <= z2_pipe[i-1];
      end
    end
    for (int i = 4; i <= 8; i++) begin
      if (en[i]) begin
        s_pipe[i] <= 31'(32'(HORNER_K[i-4]) - hp[i][61:30]);
      end
    end

    if (en[1]) begin
      tap_pipe[1] <= t_in;
      ctr_pipe[1] <= t_in == TAP_W'(HALF);
      j1          <= j_sel;
      k1          <= TAP_W'(HALF) - {1'b0, j_sel};
    end
    if (en[2]) begin
      sgn_pipe[2] <= ph_prod[15];
      z_pipe[2]   <= z_fold;
      win_pipe[2] <= WIN_ROM[j1];
      rcp_pipe[2] <= RCP_ROM[k_m1[HALF_W-1:0]];
    end
    if (en[3]) begin
      z2_pipe[3] <= zz[60:30];
    end
    if (en[9]) begin
      mag9 <= (zs_q > ONE_Q30) ? 31'(ONE_Q30) : zs_q[30:0];
    end
    if (en[10]) begin
      sinc10 <= sp[61:32];
    end
    if (en[11]) begin
      p11 <= sinc10 * win_pipe[10];
    end
    if (en[12]) begin
      coef <= ctr_pipe[11] ? cen : side;
    end
  end

  assign m_tdata = TDATA_W'({coef, tap_pipe[NS]});

endmodule

`default_nettype wire

[hdl/wsfir_chk.sv]
`default_nettype none

module wsfir_chk
  import wsfir_pkg::*;
#(
  parameter int COEF_BITS = 24
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  // [8:0] tap_number, then coefficient
  input wire logic [((TAP_W + COEF_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or vanished");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present straight after reset");

  // With the output register empty or being drained, no stage can hold the input back.
  a_accept_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input stalled although the output side is free");

  // The centre coefficient is twice the cutoff and therefore never negative.
  a_centre_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[TAP_W-1:0] == TAP_W'(HALF)) |-> !m_tdata[TAP_W+COEF_BITS-1])
    else $error("negative centre coefficient");

endmodule

bind windowed_sinc_fir_coefficient_generator_top wsfir_chk #(
  .COEF_BITS(COEF_BITS)
) u_wsfir_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[verif/windowed_sinc_fir_coefficient_generator_top_tb.sv]
`default_nettype none

module windowed_sinc_fir_coefficient_generator_top_tb;

  localparam int COEF_W       = 24;
  localparam int FRAC         = COEF_W - 3;
  localparam int TAP_W        = 9;
  localparam int OUT_W        = ((TAP_W + COEF_W + 7) / 8) * 8;
  localparam int TAP_COUNT    = 512;
  localparam int HALF_TAPS    = TAP_COUNT / 2;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 1000;
  localparam int PHASE_TAPS   = 180;

  localparam logic [2:0]  CUTOFF_ADDR      = {wsfir_pkg::REG_CUTOFF, 2'b00};
  localparam logic [2:0]  SPARE_ADDR       = {~wsfir_pkg::REG_CUTOFF, 2'b00};
  localparam logic [15:0] CUTOFF_RESET_VAL = 16'h8000;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam longint      BH0     = 385204879;
  localparam longint      BH1     = 524297395;
  localparam longint      BH2     = 151698245;
  localparam longint      BH3     = 12541305;
  localparam longint      CMAX    = (64'sd1 <<< (COEF_W - 1)) - 1;
  localparam longint      CMIN    = -CMAX - 1;

  typedef struct packed {
    logic [TAP_W-1:0]  tap;
    logic [COEF_W-1:0] coef;
  } coef_item_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata  = '0;  // [8:0] tap_index
  logic              m_tvalid;
  logic              m_tready = 1'b1;
  logic [OUT_W-1:0]  m_tdata;        // [8:0] tap_number, [32:9] coefficient
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [2:0]        paddr    = '0;
  logic [31:0]       pwdata   = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic [TAP_W-1:0]  pending_taps [$];
  coef_item_t        owed_coefs [$];
  logic [15:0]       cutoff_shadow = CUTOFF_RESET_VAL;
  logic              in_taken = 1'b0;
  logic              calm = 1'b0;
  int                in_gap = 0;
  int                out_gap = 0;
  int                taps_queued = 0;
  int                coefs_seen = 0;
  int                stall_cycles = 0;
  int                errors = 0;

  windowed_sinc_fir_coefficient_generator_top #(
    .COEF_BITS(COEF_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  // Sine of a 32-bit phase in turns, Q1.30, by quarter-wave folding and an odd polynomial.
  function automatic longint turn_sine(input logic [31:0] ph);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] acc;
    z   = ph[30] ? (Q30_ONE - {34'd0, ph[29:0]}) : {34'd0, ph[29:0]};
    z2  = (z * z) >> 30;
    acc = 64'd3864;
    acc = 64'd172272 - ((z2 * acc) >> 30);
    acc = 64'd5026995 - ((z2 * acc) >> 30);
    acc = 64'd85569306 - ((z2 * acc) >> 30);
    acc = 64'd693598668 - ((z2 * acc) >> 30);
    acc = 64'd1686629713 - ((z2 * acc) >> 30);
    acc = (z * acc) >> 30;
    if (acc > Q30_ONE) begin
      acc = Q30_ONE;
    end
    return ph[31] ? -$signed(acc) : $signed(acc);
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p  = (ma * mb) >> 30;
    return ((a < 0) != (b < 0)) ? -$signed(p) : $signed(p);
  endfunction

  function automatic longint harm_cos(input int j, input int m);
    logic [63:0] slot;
    logic [63:0] ph;
    slot = (64'(m) * 64'(j)) % 64'(TAP_COUNT);
    ph   = (slot << 32) / 64'(TAP_COUNT);
    return turn_sine(ph[31:0] + 32'h4000_0000);
  endfunction

  function automatic longint window_weight(input int j);
    longint w;
    w = BH0 - qmul(BH1, harm_cos(j, 1)) + qmul(BH2, harm_cos(j, 2))
        - qmul(BH3, harm_cos(j, 3));
    if (w < 0) begin
      w = 0;
    end
    if (w > longint'(Q30_ONE)) begin
      w = longint'(Q30_ONE);
    end
    return w;
  endfunction

  function automatic logic [COEF_W-1:0] tap_coef(input logic [TAP_W-1:0] t,
                                                 input logic [15:0] cut);
    int          j;
    int          k;
    logic [31:0] ph;
    longint      s;
    logic [63:0] ms;
    logic [63:0] d;
    logic [63:0] recip;
    logic [63:0] sinc;
    logic [63:0] mag;
    longint      c;
    if (t == HALF_TAPS) begin
      mag = (({48'd0, cut} << (FRAC + 1)) + 64'd32768) >> 16;
      c   = $signed(mag);
    end else begin
      // Taps above the centre take the value of their mirror below it.
      j     = (t < HALF_TAPS) ? int'(t) : TAP_COUNT - int'(t);
      k     = HALF_TAPS - j;
      ph    = {16'(64'(cut) * 64'(k)), 16'd0};
      s     = turn_sine(ph);
      ms    = (s < 0) ? -s : s;
      d     = PI_Q30 * 64'(k);
      recip = ((64'd1 << 62) + (d >> 1)) / d;
      sinc  = (ms * recip) >> 32;
      mag   = sinc * 64'(window_weight(j));
      mag   = (mag + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
      c     = (s < 0) ? -$signed(mag) : $signed(mag);
    end
    if (c > CMAX) begin
      c = CMAX;
    end
    if (c < CMIN) begin
      c = CMIN;
    end
    return c[COEF_W-1:0];
  endfunction

  // Mostly uniform, with extra weight near the centre and both ends of the filter.
  function automatic logic [TAP_W-1:0] random_tap();
    case ($urandom_range(0, 9))
      0: begin
        return TAP_W'($urandom_range(HALF_TAPS - 6, HALF_TAPS + 6));
      end
      1: begin
        return TAP_W'($urandom_range(0, 6));
      end
      2: begin
        return TAP_W'($urandom_range(TAP_COUNT - 6, TAP_COUNT - 1));
      end
      default: begin
        return TAP_W'($urandom);
      end
    endcase
  endfunction

  task automatic queue_tap(input logic [TAP_W-1:0] t);
    pending_taps.push_back(t);
    taps_queued++;
  endtask

  task automatic await_drain();
    while (coefs_seen < taps_queued) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_cutoff();
    logic [31:0] seen;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CUTOFF_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    seen = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (seen[15:0] !== cutoff_shadow) begin
      $display("%0t cutoff read mismatch: expected %0d, actual %0d",
               $time, cutoff_shadow, seen[15:0]);
      errors++;
    end
  endtask

  // Tap driver: holds each transaction until it is taken, with short random holes.
  always @(negedge clk) begin
    if (!rst && !(s_tvalid && !in_taken)) begin
      if (in_gap > 0) begin
        s_tvalid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pending_taps.size() > 0 && !calm && $urandom_range(0, 7) == 0) begin
        s_tvalid <= 1'b0;
        in_gap   <= $urandom_range(0, 2);
      end else if (pending_taps.size() > 0) begin
        s_tdata  <= {7'd0, pending_taps.pop_front()};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst || calm) begin
      m_tready <= 1'b1;
    end else if (out_gap > 0) begin
      m_tready <= 1'b0;
      out_gap  <= out_gap - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      out_gap  <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_results
    coef_item_t want;
    in_taken <= !rst && s_tvalid && s_tready;
    if (rst) begin
      cutoff_shadow <= CUTOFF_RESET_VAL;
    end else begin
      if (psel && penable && pwrite && pready && paddr == CUTOFF_ADDR) begin
        cutoff_shadow <= pwdata[15:0];
      end
      if (s_tvalid && s_tready) begin
        owed_coefs.push_back('{tap: s_tdata[TAP_W-1:0],
                               coef: tap_coef(s_tdata[TAP_W-1:0], cutoff_shadow)});
      end
      if (m_tvalid && m_tready) begin
        coefs_seen <= coefs_seen + 1;
        if (owed_coefs.size() == 0) begin
          $display("%0t unexpected coefficient transaction: expected none, actual %h",
                   $time, m_tdata);
          errors++;
        end else begin
          want = owed_coefs.pop_front();
          if (m_tdata[TAP_W-1:0] !== want.tap) begin
            $display("%0t tap_number mismatch: expected %0d, actual %0d",
                     $time, want.tap, m_tdata[TAP_W-1:0]);
            errors++;
          end
          if (m_tdata[TAP_W+COEF_W-1:TAP_W] !== want.coef) begin
            $display("%0t coefficient mismatch on tap %0d: expected %0d, actual %0d",
                     $time, want.tap, $signed(want.coef),
                     $signed(m_tdata[TAP_W+COEF_W-1:TAP_W]));
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [TAP_W-1:0] corner_taps [18];
    logic [15:0]      cuts [9];
    corner_taps = '{9'd0, 9'd1, 9'd2, 9'd127, 9'd128, 9'd254, 9'd255, 9'd256, 9'd257,
                    9'd258, 9'd384, 9'd509, 9'd510, 9'd511, 9'h155, 9'h0AA, 9'd85, 9'd426};
    cuts = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8001, 16'h4000, 16'h7FFF,
             16'($urandom), 16'($urandom_range(0, 32768)), 16'h8000};
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset cutoff first, including tap zero whose mirror falls past the end.
    read_cutoff();
    foreach (corner_taps[i]) begin
      queue_tap(corner_taps[i]);
    end
    await_drain();

    for (int p = 0; p < 9; p++) begin
      calm = (p == 8);
      write_reg(CUTOFF_ADDR, {16'($urandom), cuts[p]});
      // A write to the unused address must leave the cutoff alone.
      write_reg(SPARE_ADDR, $urandom);
      read_cutoff();
      for (int i = 0; i < PHASE_TAPS; i++) begin
        queue_tap(random_tap());
      end
      await_drain();
    end

    if (owed_coefs.size() != 0) begin
      $display("%0t missing coefficients: expected 0 outstanding, actual %0d",
               $time, owed_coefs.size());
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hdl/wsfir_pkg.sv
hdl/windowed_sinc_fir_coefficient_generator_top.sv
hdl/wsfir_chk.sv
verif/windowed_sinc_fir_coefficient_generator_top_tb.sv
